// File: src/ddarc_pkg.sv
// ============================================================================
// DDA raycaster package
// Shared constants, item types, divider link types and state codes.
// ============================================================================
package ddarc_pkg;

   // Map, texture and fixed point geometry
   localparam int MAP_WIDTH  = 64;
   localparam int MAP_HEIGHT = 64;
   localparam int TEX_WIDTH  = 64;
   localparam int TEX_HEIGHT = 64;
   localparam int FRAC_BITS  = 16;

   localparam int MAP_DEPTH   = MAP_WIDTH * MAP_HEIGHT;
   localparam int MAP_ADDR_W  = $clog2(MAP_DEPTH);
   localparam int CELL_W      = 12;
   localparam int GUARD_LIMIT = MAP_WIDTH + MAP_HEIGHT + 2;
   localparam int GUARD_W     = $clog2(GUARD_LIMIT + 2);

   // Field widths
   localparam int SCR_W      = 13;
   localparam int POS_W      = 22;
   localparam int VEC_W      = 19;
   localparam int COL_W      = 12;
   localparam int IDX_W      = 6;
   localparam int ROW_W      = 12;
   localparam int PERP_W     = 24;
   localparam int LINE_W     = 16;
   localparam int TEXX_W     = 6;
   localparam int TSTEP_W    = 23;

   // Internal datapath widths
   localparam int CAM_W      = 31;
   localparam int RD_W       = 36;
   localparam int DIST_W     = 39;
   localparam int RAY_PROD_W = VEC_W + CAM_W;
   localparam int DD_LOW_W   = 2 * FRAC_BITS + 1;
   localparam int SD_PROD_W  = FRAC_BITS + 1 + DD_LOW_W;
   localparam int PNUM_W     = CELL_W + FRAC_BITS + 2;
   localparam int TEXS_W     = FRAC_BITS + $clog2(TEX_WIDTH) + 1;
   localparam int TPOS_PROD_W = LINE_W - 1 + TSTEP_W;

   localparam logic [FRAC_BITS:0]  ONE_FX    = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [DIST_W-1:0]   DIST_SAT  = DIST_W'(1) << 38;
   localparam logic [PERP_W-1:0]   PERP_MAX  = '1;
   localparam logic [LINE_W-1:0]   LINE_MAX  = '1;
   localparam logic [TSTEP_W-1:0]  TEX_SAT   = TSTEP_W'(4194304);
   localparam logic [ROW_W-1:0]    ROW_MAX   = '1;

   // Serial divider
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 36;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_POS_X         = 3'd2,
      CSR_POS_Y         = 3'd3,
      CSR_DIR_X         = 3'd4,
      CSR_DIR_Y         = 3'd5,
      CSR_PLANE_X       = 3'd6,
      CSR_PLANE_Y       = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_MAP_WRITE = 1'b0,
      OP_CAST      = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FACE_SOUTH = 2'd0,
      FACE_NORTH = 2'd1,
      FACE_EAST  = 2'd2,
      FACE_WEST  = 2'd3
   } face_type;

   typedef struct packed {
      logic             operation;
      logic [COL_W-1:0] column;
      logic [IDX_W-1:0] cell_x;
      logic [IDX_W-1:0] cell_y;
      logic             cell_is_wall;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   hit_x;
      logic [IDX_W-1:0]   hit_y;
      logic               hit_side;
      logic [1:0]         wall_face;
      logic [PERP_W-1:0]  perp_distance;
      logic [LINE_W-1:0]  line_height;
      logic [ROW_W-1:0]   draw_start;
      logic [ROW_W-1:0]   draw_end;
      logic [TEXX_W-1:0]  texture_column;
      logic [TSTEP_W-1:0] texture_step;
      logic [TSTEP_W-1:0] texture_start;
      logic               escaped;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic                 busy;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_CAM,
      S_RAYX,
      S_RAYY,
      S_DDX_GO,
      S_DDX,
      S_DDY_GO,
      S_DDY,
      S_SDX,
      S_SDY,
      S_STEP,
      S_TEST,
      S_PERP_GO,
      S_PERP,
      S_LINE_GO,
      S_LINE,
      S_SPAN,
      S_STEPD,
      S_TEXM,
      S_TPOS,
      S_DONE
   } state_type;

endpackage

// File: src/dda_raycast_column_unit.sv
// ============================================================================
// DDA raycast column unit
// Wall bitmap in a synchronous memory, walked cell by cell per cast item.
// ============================================================================
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  ddarc_pkg::req_type
//  rsp      out        rsp_valid / rsp_stall  ddarc_pkg::rsp_type
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// A map write item is written as it is taken. A cast item makes up to six
// passes of the shared serial divider, plus a memory read, then a test, per
// map cell walked; fewer passes when the ray leaves the map or a ray component
// is zero. After reset the bitmap's 4096 cells are cleared; no item is taken
// then.
// The result sits in an output register, so a new item is taken while it
// waits; a cast finishing while that register is still full stalls there.
// ============================================================================
module dda_raycast_column_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ddarc_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ddarc_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddarc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddarc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ddarc_pkg::*;

   // Configuration registers
   logic [SCR_W-1:0]        scr_w_ff, scr_h_ff;
   logic [POS_W-1:0]        pos_x_ff, pos_y_ff;
   logic signed [VEC_W-1:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   // Control
   state_type               state_ff, state_in;
   logic [MAP_ADDR_W-1:0]   clr_ff, clr_in;
   logic [GUARD_W-1:0]      guard_ff, guard_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic signed [CAM_W-1:0]  cam_ff, cam_in;
   logic signed [RD_W-1:0]   rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [DIST_W-1:0]        ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [DIST_W-1:0]        sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic signed [CELL_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic                     side_ff, side_in, esc_ff, esc_in;
   logic [PERP_W-1:0]        perp_ff, perp_in;
   logic [LINE_W-1:0]        lineh_ff, lineh_in;
   logic [ROW_W-1:0]         ds_ff, ds_in, de_ff, de_in;
   logic [LINE_W-2:0]        tnum_ff, tnum_in;
   logic [TSTEP_W-1:0]       step_ff, step_in, tpos_ff, tpos_in;
   logic [FRAC_BITS-1:0]     frac_ff, frac_in;
   logic [TEXX_W-1:0]        texx_ff, texx_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Map memory
   logic                    map_mem [MAP_DEPTH];
   logic                    map_q_ff;
   logic                    wr_en, wr_data;
   logic [MAP_ADDR_W-1:0]   wr_addr, rd_addr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Combinational helpers
   logic [SCR_W-1:0]          w_eff, h_eff;
   logic signed [VEC_W-1:0]   plane_sel, dir_sel;
   logic signed [RAY_PROD_W-1:0] ray_prod;
   logic signed [RD_W-1:0]    ray_new, rd_sel, rd_other;
   logic [RD_W-1:0]           rd_abs;
   logic [FRAC_BITS:0]        sd_mul_a;
   logic [DD_LOW_W-1:0]       dd_low;
   logic [SD_PROD_W-1:0]      sd_prod, sd_shift;
   logic [DIST_W-1:0]         sd_val;
   logic [POS_W-1:0]          pos_sel, pos_other;
   logic                      step_x, in_range;
   logic [DIST_W:0]           sum_x, sum_y;
   logic signed [CELL_W-1:0]  nx, ny, cell_sel;
   logic signed [PNUM_W-1:0]  pnum;
   logic [PNUM_W-1:0]         pabs;
   logic [ROW_W-1:0]          half;
   logic [LINE_W-2:0]         lh2;
   logic [LINE_W:0]           de_sum;
   logic [2*FRAC_BITS-1:0]    tex_prod;
   logic [TEXS_W-1:0]         tex_scaled;
   logic [TPOS_PROD_W-1:0]    tpos_prod;
   logic                      mirror, cast_acc;
   logic [DIV_NUM_W-1:0]      q;

   assign w_eff = (scr_w_ff == '0) ? SCR_W'(1) : scr_w_ff;
   assign h_eff = (scr_h_ff == '0) ? SCR_W'(1) : scr_h_ff;
   assign q     = div_rsp.quotient;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff   <= SCR_W'(640);
         scr_h_ff   <= SCR_W'(480);
         pos_x_ff   <= POS_W'(98304);
         pos_y_ff   <= POS_W'(98304);
         dir_x_ff   <= -VEC_W'(65536);
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= VEC_W'(43254);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  scr_w_ff   <= csr_data[SCR_W-1:0];
            CSR_SCREEN_HEIGHT: scr_h_ff   <= csr_data[SCR_W-1:0];
            CSR_POS_X:         pos_x_ff   <= csr_data[POS_W-1:0];
            CSR_POS_Y:         pos_y_ff   <= csr_data[POS_W-1:0];
            CSR_DIR_X:         dir_x_ff   <= csr_data[VEC_W-1:0];
            CSR_DIR_Y:         dir_y_ff   <= csr_data[VEC_W-1:0];
            CSR_PLANE_X:       plane_x_ff <= csr_data[VEC_W-1:0];
            CSR_PLANE_Y:       plane_y_ff <= csr_data[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   // Shared arithmetic, steered by the state
   always_comb begin
      plane_sel = (state_ff == S_RAYX) ? plane_x_ff : plane_y_ff;
      dir_sel   = (state_ff == S_RAYX) ? dir_x_ff : dir_y_ff;
      ray_prod  = RAY_PROD_W'(plane_sel) * RAY_PROD_W'(cam_ff);
      ray_new   = RD_W'(ray_prod >>> FRAC_BITS) + RD_W'(dir_sel);

      // x axis in the x states and on side 0, y axis otherwise
      if (state_ff == S_DDX_GO || state_ff == S_SDX) begin
         rd_sel  = rdx_ff;
         pos_sel = pos_x_ff;
         dd_low  = ddx_ff[DD_LOW_W-1:0];
      end else if (state_ff == S_DDY_GO || state_ff == S_SDY) begin
         rd_sel  = rdy_ff;
         pos_sel = pos_y_ff;
         dd_low  = ddy_ff[DD_LOW_W-1:0];
      end else begin
         rd_sel  = side_ff ? rdy_ff : rdx_ff;
         pos_sel = side_ff ? pos_y_ff : pos_x_ff;
         dd_low  = ddx_ff[DD_LOW_W-1:0];
      end
      rd_other  = side_ff ? rdx_ff : rdy_ff;
      pos_other = side_ff ? pos_x_ff : pos_y_ff;
      rd_abs    = rd_sel[RD_W-1] ? RD_W'(-rd_sel) : RD_W'(rd_sel);

      sd_mul_a = rd_sel[RD_W-1] ? {1'b0, pos_sel[FRAC_BITS-1:0]}
                                : ONE_FX - {1'b0, pos_sel[FRAC_BITS-1:0]};
      sd_prod  = SD_PROD_W'(sd_mul_a) * SD_PROD_W'(dd_low);
      sd_shift = sd_prod >> FRAC_BITS;
      if (rd_sel == '0) begin
         sd_val = DIST_SAT;
      end else if (sd_shift > SD_PROD_W'(DIST_SAT)) begin
         sd_val = DIST_SAT;
      end else begin
         sd_val = DIST_W'(sd_shift);
      end

      // One DDA step
      step_x = sdx_ff < sdy_ff;
      sum_x  = {1'b0, sdx_ff} + {1'b0, ddx_ff};
      sum_y  = {1'b0, sdy_ff} + {1'b0, ddy_ff};
      nx = mx_ff;
      ny = my_ff;
      if (step_x) begin
         nx = rdx_ff[RD_W-1] ? mx_ff - CELL_W'(1) : mx_ff + CELL_W'(1);
      end else begin
         ny = rdy_ff[RD_W-1] ? my_ff - CELL_W'(1) : my_ff + CELL_W'(1);
      end
      in_range = !nx[CELL_W-1] && !ny[CELL_W-1] &&
                 (nx < CELL_W'(MAP_WIDTH)) && (ny < CELL_W'(MAP_HEIGHT));
      rd_addr  = MAP_ADDR_W'(int'(ny) * MAP_WIDTH + int'(nx));

      // Distance numerator along the crossed axis
      cell_sel = side_ff ? my_ff : mx_ff;
      pnum = (PNUM_W'(cell_sel) <<< FRAC_BITS) - PNUM_W'(pos_sel)
           + (rd_sel[RD_W-1] ? PNUM_W'(ONE_FX) : PNUM_W'(0));
      pabs = pnum[PNUM_W-1] ? PNUM_W'(-pnum) : PNUM_W'(pnum);

      // Span
      half   = ROW_W'(h_eff >> 1);
      lh2    = lineh_ff[LINE_W-1:1];
      de_sum = (LINE_W + 1)'(lh2) + (LINE_W + 1)'(half);

      // Only the fraction of the wall coordinate is needed, so the low
      // product bits suffice.
      tex_prod   = (2 * FRAC_BITS)'(perp_ff) * rd_other[2*FRAC_BITS-1:0];
      tex_scaled = (TEXS_W'(frac_ff) * TEXS_W'(TEX_WIDTH)) >> FRAC_BITS;
      mirror     = (!side_ff && !rdx_ff[RD_W-1] && rdx_ff != '0) ||
                   (side_ff && rdy_ff[RD_W-1]);
      tpos_prod  = TPOS_PROD_W'(tnum_ff) * TPOS_PROD_W'(step_ff);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      guard_in     = guard_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cam_in   = cam_ff;
      rdx_in   = rdx_ff;
      rdy_in   = rdy_ff;
      ddx_in   = ddx_ff;
      ddy_in   = ddy_ff;
      sdx_in   = sdx_ff;
      sdy_in   = sdy_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      side_in  = side_ff;
      esc_in   = esc_ff;
      perp_in  = perp_ff;
      lineh_in = lineh_ff;
      ds_in    = ds_ff;
      de_in    = de_ff;
      tnum_in  = tnum_ff;
      step_in  = step_ff;
      tpos_in  = tpos_ff;
      frac_in  = frac_ff;
      texx_in  = texx_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      wr_en   = 1'b0;
      wr_addr = MAP_ADDR_W'(int'(req_data.cell_y) * MAP_WIDTH + int'(req_data.cell_x));
      wr_data = req_data.cell_is_wall;
      cast_acc = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 1'b0;
            clr_in  = clr_ff + MAP_ADDR_W'(1);
            if (clr_ff == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (op_type'(req_data.operation) == OP_CAST) begin
                  cast_acc         = 1'b1;
                  esc_in           = 1'b0;
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_NUM_W'(req_data.column) << (FRAC_BITS + 1);
                  div_req.divisor  = DIV_DEN_W'(w_eff);
                  state_in         = S_CAM;
               end else begin
                  wr_en = (int'(req_data.cell_x) < MAP_WIDTH) &&
                          (int'(req_data.cell_y) < MAP_HEIGHT);
               end
            end
         end
         S_CAM: begin
            if (div_rsp.done) begin
               cam_in   = CAM_W'(q) - CAM_W'(ONE_FX);
               state_in = S_RAYX;
            end
         end
         S_RAYX: begin
            rdx_in   = ray_new;
            state_in = S_RAYY;
         end
         S_RAYY: begin
            rdy_in   = ray_new;
            state_in = S_DDX_GO;
         end
         S_DDX_GO, S_DDY_GO: begin
            if (rd_sel == '0) begin
               if (state_ff == S_DDX_GO) begin
                  ddx_in   = DIST_SAT;
                  state_in = S_DDY_GO;
               end else begin
                  ddy_in   = DIST_SAT;
                  state_in = S_SDX;
               end
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'(1) << (2 * FRAC_BITS);
               div_req.divisor  = DIV_DEN_W'(rd_abs);
               state_in = (state_ff == S_DDX_GO) ? S_DDX : S_DDY;
            end
         end
         S_DDX: begin
            if (div_rsp.done) begin
               ddx_in   = (q > DIV_NUM_W'(DIST_SAT)) ? DIST_SAT : DIST_W'(q);
               state_in = S_DDY_GO;
            end
         end
         S_DDY: begin
            if (div_rsp.done) begin
               ddy_in   = (q > DIV_NUM_W'(DIST_SAT)) ? DIST_SAT : DIST_W'(q);
               state_in = S_SDX;
            end
         end
         S_SDX: begin
            sdx_in   = sd_val;
            state_in = S_SDY;
         end
         S_SDY: begin
            sdy_in   = sd_val;
            mx_in    = CELL_W'(pos_x_ff[POS_W-1:FRAC_BITS]);
            my_in    = CELL_W'(pos_y_ff[POS_W-1:FRAC_BITS]);
            guard_in = '0;
            side_in  = 1'b1;
            if (int'(pos_x_ff[POS_W-1:FRAC_BITS]) >= MAP_WIDTH ||
                int'(pos_y_ff[POS_W-1:FRAC_BITS]) >= MAP_HEIGHT) begin
               esc_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (guard_ff > GUARD_W'(GUARD_LIMIT)) begin
               esc_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               guard_in = guard_ff + GUARD_W'(1);
               mx_in    = nx;
               my_in    = ny;
               side_in  = !step_x;
               if (step_x) begin
                  sdx_in = (sum_x > (DIST_W + 1)'(DIST_SAT)) ? DIST_SAT : DIST_W'(sum_x);
               end else begin
                  sdy_in = (sum_y > (DIST_W + 1)'(DIST_SAT)) ? DIST_SAT : DIST_W'(sum_y);
               end
               if (in_range) begin
                  state_in = S_TEST;
               end else begin
                  esc_in   = 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_TEST: begin
            state_in = map_q_ff ? S_PERP_GO : S_STEP;
         end
         S_PERP_GO: begin
            if (rd_sel == '0) begin
               perp_in  = PERP_MAX;
               state_in = S_LINE_GO;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'(pabs) << FRAC_BITS;
               div_req.divisor  = DIV_DEN_W'(rd_abs);
               state_in         = S_PERP;
            end
         end
         S_PERP: begin
            if (div_rsp.done) begin
               perp_in  = (q > DIV_NUM_W'(PERP_MAX)) ? PERP_MAX : PERP_W'(q);
               state_in = S_LINE_GO;
            end
         end
         S_LINE_GO: begin
            if (perp_ff == '0) begin
               lineh_in = LINE_MAX;
               state_in = S_SPAN;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'(h_eff) << FRAC_BITS;
               div_req.divisor  = DIV_DEN_W'(perp_ff);
               state_in         = S_LINE;
            end
         end
         S_LINE: begin
            if (div_rsp.done) begin
               lineh_in = (q > DIV_NUM_W'(LINE_MAX)) ? LINE_MAX : LINE_W'(q);
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            if ((LINE_W - 1)'(half) > lh2) begin
               ds_in   = half - ROW_W'(lh2);
               tnum_in = '0;
            end else begin
               ds_in   = '0;
               tnum_in = lh2 - (LINE_W - 1)'(half);
            end
            if (de_sum >= (LINE_W + 1)'(h_eff)) begin
               de_in = ROW_W'(h_eff - SCR_W'(1));
            end else if (de_sum > (LINE_W + 1)'(ROW_MAX)) begin
               de_in = ROW_MAX;
            end else begin
               de_in = ROW_W'(de_sum);
            end
            if (h_eff > SCR_W'(ROW_MAX) && de_sum >= (LINE_W + 1)'(h_eff)) begin
               de_in = ROW_MAX;
            end
            if (lineh_ff == '0) begin
               step_in  = TEX_SAT;
               state_in = S_TEXM;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_NUM_W'(TEX_HEIGHT) << FRAC_BITS;
               div_req.divisor  = DIV_DEN_W'(lineh_ff);
               state_in         = S_STEPD;
            end
         end
         S_STEPD: begin
            if (div_rsp.done) begin
               step_in  = (q > DIV_NUM_W'(TEX_SAT)) ? TEX_SAT : TSTEP_W'(q);
               state_in = S_TEXM;
            end
         end
         S_TEXM: begin
            frac_in  = pos_other[FRAC_BITS-1:0] + tex_prod[2*FRAC_BITS-1:FRAC_BITS];
            state_in = S_TPOS;
         end
         S_TPOS: begin
            tpos_in  = (tpos_prod > TPOS_PROD_W'(TEX_SAT)) ? TEX_SAT : TSTEP_W'(tpos_prod);
            texx_in  = mirror ? TEXX_W'(TEXS_W'(TEX_WIDTH - 1) - tex_scaled)
                              : TEXX_W'(tex_scaled);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (esc_ff) begin
                  rsp_data_in.escaped = 1'b1;
               end else begin
                  rsp_data_in.hit_x          = IDX_W'(mx_ff);
                  rsp_data_in.hit_y          = IDX_W'(my_ff);
                  rsp_data_in.hit_side       = side_ff;
                  if (!side_ff) begin
                     rsp_data_in.wall_face = rdx_ff[RD_W-1] ? FACE_NORTH : FACE_SOUTH;
                  end else begin
                     rsp_data_in.wall_face = rdy_ff[RD_W-1] ? FACE_WEST : FACE_EAST;
                  end
                  rsp_data_in.perp_distance  = perp_ff;
                  rsp_data_in.line_height    = lineh_ff;
                  rsp_data_in.draw_start     = ds_ff;
                  rsp_data_in.draw_end       = de_ff;
                  rsp_data_in.texture_column = texx_ff;
                  rsp_data_in.texture_step   = step_ff;
                  rsp_data_in.texture_start  = tpos_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         guard_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         guard_ff     <= guard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      cam_ff   <= cam_in;
      rdx_ff   <= rdx_in;
      rdy_ff   <= rdy_in;
      ddx_ff   <= ddx_in;
      ddy_ff   <= ddy_in;
      sdx_ff   <= sdx_in;
      sdy_ff   <= sdy_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      side_ff  <= side_in;
      esc_ff   <= esc_in;
      perp_ff  <= perp_in;
      lineh_ff <= lineh_in;
      ds_ff    <= ds_in;
      de_ff    <= de_in;
      tnum_ff  <= tnum_in;
      step_ff  <= step_in;
      tpos_ff  <= tpos_in;
      frac_ff  <= frac_in;
      texx_ff  <= texx_in;
   end

   // Wall bitmap: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      map_q_ff <= map_mem[rd_addr];
   end

   ddarc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

`ifndef SYNTHESIS
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff && !div_rsp.busy)
      else $error("activity during bitmap clear");
   a_guard_bound: assert property (@(posedge clock) disable iff (reset)
      guard_ff <= GUARD_W'(GUARD_LIMIT + 1)) else $error("walk guard overran");
   a_test_in_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TEST |-> !mx_ff[CELL_W-1] && !my_ff[CELL_W-1] &&
      mx_ff < CELL_W'(MAP_WIDTH) && my_ff < CELL_W'(MAP_HEIGHT))
      else $error("cell tested outside the map");
   a_cast_starts_div: assert property (@(posedge clock) disable iff (reset)
      cast_acc |=> div_rsp.busy) else $error("cast item did not start divider");
`endif

endmodule

// File: src/ddarc_divider.sv
// ============================================================================
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
module ddarc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  ddarc_pkg::div_req_type div_req,
   output ddarc_pkg::div_rsp_type div_rsp
);
   import ddarc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = quo_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while still busy");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff == DIV_CNT_W'(1) && !div_req.start |=> done_ff)
      else $error("divider missed its last step");
`endif

endmodule
